@@ hw/rtl/xor_sync_frame_deframer_assert.svh @@
// Assertion macros for the sync-word deframer checker.
// Included by the checker file; no other dependencies.
`ifndef XOR_SYNC_FRAME_DEFRAMER_ASSERT_SVH
`define XOR_SYNC_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define XSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled during reset
`define XSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

@@ hw/rtl/xsd_pkg.sv @@
// Shared types and constants for the sync-word deframer.
// No dependencies.
`timescale 1ns / 1ps

package xsd_pkg;

    // parse modes
    localparam logic [2:0] MODE_HUNT1 = 3'd0;
    localparam logic [2:0] MODE_HUNT2 = 3'd1;
    localparam logic [2:0] MODE_LENLO = 3'd2;
    localparam logic [2:0] MODE_LENHI = 3'd3;
    localparam logic [2:0] MODE_BODY  = 3'd4;
    localparam logic [2:0] MODE_STOP  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_KEY     = 2'd0;
    localparam logic [1:0] REG_SYNC1   = 2'd1;
    localparam logic [1:0] REG_SYNC2   = 2'd2;
    localparam logic [1:0] REG_MIN_LEN = 2'd3;

    localparam logic [7:0]  KEY_RESET     = 8'hAD;
    localparam logic [7:0]  SYNC1_RESET   = 8'hC0;
    localparam logic [7:0]  SYNC2_RESET   = 8'h91;
    localparam logic [15:0] MIN_LEN_RESET = 16'd7;
    localparam logic [15:0] HEADER_LEN    = 16'd4;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int MAX_PUSH    = 4;

    typedef struct packed {
        logic [7:0]  scramble_key;
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] min_frame_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_first;
        logic       frame_final;
        logic       frame_abort;
        logic       run_last;
    } res_t;

    typedef struct packed {
        logic [2:0]              count;
        res_t [MAX_PUSH-1:0]     item;
    } push_t;

endpackage

@@ hw/rtl/xor_sync_frame_deframer.sv @@
// An accepted byte's first result is on the output in the cycle after it is accepted if the queue is empty.
// Throughput: one wire byte per cycle while in_stall is low; a frame header is a burst of four results.
// in_stall rises only while more than four results wait in the 8-entry result queue.
// Reset (rst_n low, asynchronous) restores default registers, hunting mode,
// and an empty queue. Top level; depends on xsd_pkg and the xsd_* modules.
`timescale 1ns / 1ps

module xor_sync_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  wire_byte,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_first,
    output logic        frame_final,
    output logic        frame_abort,
    output logic        run_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import xsd_pkg::*;

    cfg_t  cfg;
    push_t push;
    res_t  head;
    logic  room;
    logic  in_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign in_fire   = in_valid && room;

    xsd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    xsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .wire_byte  (wire_byte),
        .buffer_end (buffer_end),
        .cfg        (cfg),
        .push       (push)
    );

    xsd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign frame_byte  = head.frame_byte;
    assign frame_first = head.frame_first;
    assign frame_final = head.frame_final;
    assign frame_abort = head.frame_abort;
    assign run_last    = head.run_last;

endmodule

@@ hw/rtl/xsd_cfg_regs.sv @@
// Configuration register file for the sync-word deframer.
// Depends on xsd_pkg.
`timescale 1ns / 1ps

module xsd_cfg_regs (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [1:0]   wr_index,
    input  logic [15:0]  wr_data,
    output xsd_pkg::cfg_t cfg
);
    import xsd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scramble_key     <= KEY_RESET;
            cfg_reg.sync_first       <= SYNC1_RESET;
            cfg_reg.sync_second      <= SYNC2_RESET;
            cfg_reg.min_frame_length <= MIN_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KEY:     cfg_reg.scramble_key     <= wr_data[7:0];
                REG_SYNC1:   cfg_reg.sync_first       <= wr_data[7:0];
                REG_SYNC2:   cfg_reg.sync_second      <= wr_data[7:0];
                REG_MIN_LEN: cfg_reg.min_frame_length <= wr_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/xsd_parser.sv @@
// Descrambler and frame parser: one wire byte in, up to four results out.
// Depends on xsd_pkg.
`timescale 1ns / 1ps

module xsd_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [7:0]    wire_byte,
    input  logic          buffer_end,
    input  xsd_pkg::cfg_t cfg,
    output xsd_pkg::push_t push
);
    import xsd_pkg::*;

    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] remain_reg, remain_next;

    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] remain_dec;
    logic        short_len;

    assign b          = wire_byte ^ cfg.scramble_key;
    assign len        = {b, len_lo_reg};
    assign remain_dec = remain_reg - 16'd1;
    assign short_len  = (len < HEADER_LEN) || (len < cfg.min_frame_length);

    always_comb
    begin
        mode_next   = mode_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        push        = '0;

        unique case (mode_reg)
            MODE_HUNT2:
            begin
                if (b == cfg.sync_second)
                    mode_next = MODE_LENLO;
                else if (b != cfg.sync_first)
                    mode_next = MODE_HUNT1;
            end
            MODE_LENLO:
            begin
                len_lo_next = b;
                mode_next   = MODE_LENHI;
            end
            MODE_LENHI:
            begin
                if (short_len)
                    mode_next = MODE_STOP;
                else
                begin
                    push.count = 3'd4;
                    push.item[0] = '{frame_byte: cfg.sync_first, frame_first: 1'b1,
                                     frame_final: 1'b0, frame_abort: 1'b0, run_last: 1'b0};
                    push.item[1] = '{frame_byte: cfg.sync_second, frame_first: 1'b0,
                                     frame_final: 1'b0, frame_abort: 1'b0, run_last: 1'b0};
                    push.item[2] = '{frame_byte: len_lo_reg, frame_first: 1'b0,
                                     frame_final: 1'b0, frame_abort: 1'b0, run_last: 1'b0};
                    if (len == HEADER_LEN)
                    begin
                        push.item[3] = '{frame_byte: b, frame_first: 1'b0,
                                         frame_final: 1'b1, frame_abort: 1'b0,
                                         run_last: 1'b1};
                        mode_next = MODE_HUNT1;
                    end
                    else
                    begin
                        push.item[3] = '{frame_byte: b, frame_first: 1'b0,
                                         frame_final: 1'b0, frame_abort: buffer_end,
                                         run_last: 1'b1};
                        remain_next = len - HEADER_LEN;
                        mode_next   = MODE_BODY;
                    end
                end
            end
            MODE_BODY:
            begin
                remain_next = remain_dec;
                push.count  = 3'd1;
                if (remain_dec == 16'd0)
                begin
                    push.item[0] = '{frame_byte: b, frame_first: 1'b0, frame_final: 1'b1,
                                     frame_abort: 1'b0, run_last: 1'b1};
                    mode_next = MODE_HUNT1;
                end
                else
                    push.item[0] = '{frame_byte: b, frame_first: 1'b0, frame_final: 1'b0,
                                     frame_abort: buffer_end, run_last: 1'b1};
            end
            MODE_STOP:
                mode_next = MODE_STOP;
            default:
                mode_next = (b == cfg.sync_first) ? MODE_HUNT2 : MODE_HUNT1;
        endcase

        // every buffer end restarts the hunt
        if (buffer_end)
        begin
            mode_next   = MODE_HUNT1;
            len_lo_next = 8'd0;
            remain_next = 16'd0;
        end

        if (!in_fire)
            push.count = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT1;
            len_lo_reg <= 8'd0;
            remain_reg <= 16'd0;
        end
        else if (in_fire)
        begin
            mode_reg   <= mode_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
        end
    end

endmodule

@@ hw/rtl/xsd_out_queue.sv @@
// Result queue: takes up to four results a cycle, delivers one a cycle while out_stall is low.
// Depends on xsd_pkg.
`timescale 1ns / 1ps

module xsd_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  xsd_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_stall,
    output xsd_pkg::res_t  head
);
    import xsd_pkg::*;

    res_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_PUSH));
    assign head      = entries_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            if (3'(i) < push.count)
                entries_reg[wptr_reg + QUEUE_AW'(i)] <= push.item[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + QUEUE_AW'(push.count);
            rptr_reg  <= rptr_reg + QUEUE_AW'(pop);
            count_reg <= count_reg + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(pop);
        end
    end

endmodule

@@ hw/rtl/xsd_checker.sv @@
// Port-level checks for the sync-word deframer, bound to the top level.
// Depends on xor_sync_frame_deframer_assert.svh.
`timescale 1ns / 1ps
`include "xor_sync_frame_deframer_assert.svh"

module xsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       frame_first,
    input logic       frame_final,
    input logic       frame_abort,
    input logic       run_last
);

    // a stalled transaction stays valid and holds its byte and run_last flag
    `XSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(frame_byte) && $stable(run_last))

    `XSD_ASSERT_NOW(a_final_xor_abort, clk, rst_n, out_valid, !(frame_final && frame_abort))

    // header start is never the last result of its byte
    `XSD_ASSERT_NOW(a_first_not_last, clk, rst_n, out_valid && frame_first, !run_last)

    `XSD_ASSERT_NOW(a_final_is_last, clk, rst_n, out_valid && frame_final, run_last)

endmodule

bind xor_sync_frame_deframer xsd_checker u_xsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .frame_first (frame_first),
    .frame_final (frame_final),
    .frame_abort (frame_abort),
    .run_last    (run_last)
);
